### rtl/fsc_pkg.sv
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared codes, types and helpers of the frustum sphere culler.
// ----------------------------------------------------------------------------
package fsc_pkg;

  localparam logic [1:0] ACT_VIEW   = 2'd0;
  localparam logic [1:0] ACT_PROJ   = 2'd1;
  localparam logic [1:0] ACT_UPDATE = 2'd2;
  localparam logic [1:0] ACT_TEST   = 2'd3;

  localparam logic [1:0] MODE_MUL  = 2'd0;
  localparam logic [1:0] MODE_SQ   = 2'd1;
  localparam logic [1:0] MODE_TEST = 2'd2;

  // Accumulator width: holds three squared 32-bit values or four shifted products.
  localparam int ACC_W = 66;
  localparam int CNT_W = 7;

  typedef struct packed {
    logic       wr_view;
    logic       wr_proj;
    logic       load_sphere;
    logic       clear_cull;
    logic       issue;
    logic       first;
    logic       last;
    logic [1:0] mode;
    logic [1:0] row;
    logic [1:0] col;
    logic [1:0] kk;
    logic [2:0] plane;
    logic [1:0] comp;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       div_write;
  } cmd_t;

  typedef struct packed {
    logic culled;
  } stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > ACC_W'(signed'(32'sh7fffffff))) r = 32'sh7fffffff;
    else if (v < ACC_W'(signed'(32'sh80000000))) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

### rtl/frustum_sphere_culler.sv
// ----------------------------------------------------------------------------
// frustum_sphere_culler
// Builds six normalised frustum planes from view and projection matrices and
// tests spheres against them.
// ----------------------------------------------------------------------------
// Element writes leave busy low. A sphere test keeps busy high through
// 24 passes of the shared 32x32 multiplier (four per plane) and the
// pipeline that follows, and inside_valid then pulses for one cycle with
// inside_res; the receiver cannot stall it. A plane update runs 64
// multiplies for the matrix product, then per plane a sum of squares, a
// 32-step square root and four bit-serial divisions.
module frustum_sphere_culler #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic [1:0]         matrix_row,
  input  logic [1:0]         matrix_col,
  input  logic signed [31:0] element_value,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic [30:0]        sphere_radius,
  output logic               inside_valid,
  output logic               inside_res
);
  import fsc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  fsc_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .action       (action),
    .busy         (busy),
    .inside_valid (inside_valid),
    .inside_res   (inside_res),
    .cmd          (cmd),
    .stat         (stat)
  );

  fsc_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .matrix_row    (matrix_row),
    .matrix_col    (matrix_col),
    .element_value (element_value),
    .center_x      (center_x),
    .center_y      (center_y),
    .center_z      (center_z),
    .sphere_radius (sphere_radius)
  );

`ifndef SYNTH
  a_test_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_TEST) |=> busy)
    else $error("sphere test transfer did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    inside_valid |=> !inside_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_after_work: assert property (@(posedge clk) disable iff (rst)
    inside_valid |-> $past(busy))
    else $error("result without a test in progress");
`endif

endmodule

### rtl/fsc_ctrl.sv
// ----------------------------------------------------------------------------
// fsc_ctrl
// Sequencer: steps the datapath through the matrix product, plane
// normalisation and sphere test, and drives the result strobe.
// ----------------------------------------------------------------------------
module fsc_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    action,
  output logic          busy,
  output logic          inside_valid,
  output logic          inside_res,
  output fsc_pkg::cmd_t cmd,
  input  fsc_pkg::stat_t stat
);
  import fsc_pkg::*;

  localparam int QW = 32 + FRAC_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_NSQ  = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_TEST = 3'd5;

  logic [2:0]       state;
  logic [CNT_W-1:0] cnt;
  logic [2:0]       plane;
  logic [1:0]       comp;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.wr_view     = (action == ACT_VIEW);
          cmd.wr_proj     = (action == ACT_PROJ);
          cmd.load_sphere = (action == ACT_TEST);
          cmd.clear_cull  = (action == ACT_TEST);
        end
      end
      S_MUL: begin
        cmd.mode  = MODE_MUL;
        cmd.issue = (cnt < CNT_W'(64));
        cmd.row   = cnt[5:4];
        cmd.col   = cnt[3:2];
        cmd.kk    = cnt[1:0];
        cmd.first = (cnt[1:0] == 2'd0);
        cmd.last  = (cnt[1:0] == 2'd3);
      end
      S_NSQ: begin
        cmd.mode  = MODE_SQ;
        cmd.issue = (cnt < CNT_W'(3));
        cmd.plane = plane;
        cmd.comp  = cnt[1:0];
        cmd.first = (cnt == '0);
      end
      S_SQRT: begin
        cmd.sqrt_init = (cnt == '0);
        cmd.sqrt_step = (cnt != '0);
      end
      S_DIV: begin
        cmd.plane     = plane;
        cmd.comp      = comp;
        cmd.div_init  = (cnt == '0);
        cmd.div_step  = (cnt != '0) && (cnt <= CNT_W'(QW));
        cmd.div_write = (cnt == CNT_W'(QW + 1));
      end
      S_TEST: begin
        cmd.mode  = MODE_TEST;
        cmd.issue = (cnt < CNT_W'(24));
        cmd.plane = cnt[4:2];
        cmd.comp  = cnt[1:0];
        cmd.first = (cnt[1:0] == 2'd0);
        cmd.last  = (cnt[1:0] == 2'd3);
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      plane        <= '0;
      comp         <= '0;
      inside_valid <= 1'b0;
      inside_res   <= 1'b0;
    end else begin
      inside_valid <= 1'b0;
      cnt          <= cnt + 1'b1;
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (start && action == ACT_UPDATE) state <= S_MUL;
          if (start && action == ACT_TEST) state <= S_TEST;
        end
        S_MUL: begin
          // Wait for the last product to pass prod and p_row into the raw plane rows.
          if (cnt == CNT_W'(65)) begin
            state <= S_NSQ;
            cnt   <= '0;
            plane <= '0;
          end
        end
        S_NSQ: begin
          if (cnt == CNT_W'(3)) begin
            state <= S_SQRT;
            cnt   <= '0;
          end
        end
        S_SQRT: begin
          if (cnt == CNT_W'(32)) begin
            state <= S_DIV;
            cnt   <= '0;
            comp  <= '0;
          end
        end
        S_DIV: begin
          if (cnt == CNT_W'(QW + 1)) begin
            cnt <= '0;
            if (comp == 2'd3) begin
              if (plane == 3'd5) begin
                state <= S_IDLE;
              end else begin
                plane <= plane + 1'b1;
                state <= S_NSQ;
              end
            end else begin
              comp <= comp + 1'b1;
            end
          end
        end
        S_TEST: begin
          if (cnt == CNT_W'(25)) begin
            state        <= S_IDLE;
            inside_valid <= 1'b1;
            inside_res   <= ~stat.culled;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/fsc_dp.sv
// ----------------------------------------------------------------------------
// fsc_dp
// Datapath: matrix stores, shared multiplier and accumulator, plane rows,
// square root and divider units, and the normalised plane store.
// ----------------------------------------------------------------------------
module fsc_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  fsc_pkg::cmd_t      cmd,
  output fsc_pkg::stat_t     stat,
  input  logic [1:0]         matrix_row,
  input  logic [1:0]         matrix_col,
  input  logic signed [31:0] element_value,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic [30:0]        sphere_radius
);
  import fsc_pkg::*;

  localparam int QW = 32 + FRAC_BITS;

  logic signed [31:0] view_m [16];
  logic signed [31:0] proj_m [16];
  logic signed [31:0] pl     [24];
  logic signed [31:0] p_row  [4];
  logic signed [31:0] raw    [6][4];

  logic signed [31:0] cx, cy, cz;
  logic [30:0]        rad;

  logic signed [31:0] op_a, op_b, raw_sel;
  logic signed [63:0] prod, prod_shift;
  logic signed [ACC_W-1:0] acc, term, sum, limit, c3, qext, qval;
  logic [ACC_W-1:0]   rmag;

  logic       d1_issue, d1_first, d1_last, d1_rowend, d2_rowend;
  logic [1:0] d1_mode, d1_col, d1_row, d2_row;

  logic [63:0] sq_rem, sq_res, sq_bit, sq_t;
  logic [31:0] len;

  logic [QW-1:0] dvd, quo;
  logic [31:0]   drem;
  logic          dneg;
  logic [32:0]   remw, rext, rmagn;
  logic          ge;
  logic          culled;

  assign raw_sel = raw[cmd.plane][cmd.comp];

  always_comb begin
    case (cmd.mode)
      MODE_MUL: begin
        op_a = view_m[{cmd.row, cmd.kk}];
        op_b = proj_m[{cmd.kk, cmd.col}];
      end
      MODE_SQ: begin
        op_a = raw_sel;
        op_b = raw_sel;
      end
      MODE_TEST: begin
        op_a = pl[{cmd.plane, cmd.comp}];
        case (cmd.comp)
          2'd0:    op_b = cx;
          2'd1:    op_b = cy;
          2'd2:    op_b = cz;
          default: op_b = 32'sd1 <<< FRAC_BITS;
        endcase
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Matrix terms are floored to the fixed-point grid before they are summed.
  assign prod_shift = prod >>> FRAC_BITS;
  assign term  = (d1_mode == MODE_MUL) ? ACC_W'(prod_shift) : ACC_W'(prod);
  assign sum   = (d1_first ? '0 : acc) + term;
  assign rmag  = ACC_W'(rad) << FRAC_BITS;
  assign limit = -signed'(rmag);
  assign c3    = ACC_W'(p_row[3]);

  assign sq_t = sq_res + sq_bit;
  assign len  = sq_res[31:0];

  assign remw  = {drem, dvd[QW-1]};
  assign ge    = (remw >= {1'b0, len});
  assign rext  = 33'(raw_sel);
  assign rmagn = raw_sel[31] ? -rext : rext;
  assign qext  = ACC_W'(quo);
  assign qval  = dneg ? -qext : qext;

  assign stat.culled = culled;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < 16; n++) begin
        view_m[n] <= '0;
        proj_m[n] <= '0;
      end
      for (int n = 0; n < 24; n++) pl[n] <= '0;
      d1_issue  <= 1'b0;
      d1_rowend <= 1'b0;
      d2_rowend <= 1'b0;
      culled    <= 1'b0;
    end else begin
      if (cmd.wr_view) view_m[{matrix_row, matrix_col}] <= element_value;
      if (cmd.wr_proj) proj_m[{matrix_row, matrix_col}] <= element_value;

      d1_issue  <= cmd.issue;
      d1_rowend <= cmd.issue && cmd.last && (cmd.mode == MODE_MUL) && (cmd.col == 2'd3);
      d2_rowend <= d1_rowend;

      if (cmd.clear_cull) culled <= 1'b0;
      else if (d1_issue && d1_last && d1_mode == MODE_TEST && sum < limit) culled <= 1'b1;

      if (cmd.div_write) begin
        if (len == '0) pl[{cmd.plane, cmd.comp}] <= '0;
        else pl[{cmd.plane, cmd.comp}] <= sat32(qval);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sphere) begin
      cx  <= center_x;
      cy  <= center_y;
      cz  <= center_z;
      rad <= sphere_radius;
    end

    prod     <= op_a * op_b;
    d1_first <= cmd.first;
    d1_last  <= cmd.last;
    d1_mode  <= cmd.mode;
    d1_col   <= cmd.col;
    d1_row   <= cmd.row;
    d2_row   <= d1_row;

    if (d1_issue) begin
      acc <= sum;
      if (d1_last && d1_mode == MODE_MUL) p_row[d1_col] <= sat32(sum);
    end

    // A finished product row yields one component of every raw plane.
    if (d2_rowend) begin
      raw[0][d2_row] <= sat32(c3 + ACC_W'(p_row[0]));
      raw[1][d2_row] <= sat32(c3 - ACC_W'(p_row[0]));
      raw[2][d2_row] <= sat32(c3 + ACC_W'(p_row[1]));
      raw[3][d2_row] <= sat32(c3 - ACC_W'(p_row[1]));
      raw[4][d2_row] <= p_row[2];
      raw[5][d2_row] <= sat32(c3 - ACC_W'(p_row[2]));
    end

    if (cmd.sqrt_init) begin
      sq_rem <= acc[63:0];
      sq_res <= '0;
      sq_bit <= 64'd1 << 62;
    end else if (cmd.sqrt_step) begin
      if (sq_rem >= sq_t) begin
        sq_rem <= sq_rem - sq_t;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end

    if (cmd.div_init) begin
      dvd  <= QW'(rmagn[31:0]) << FRAC_BITS;
      dneg <= raw_sel[31];
      drem <= '0;
      quo  <= '0;
    end else if (cmd.div_step) begin
      drem <= ge ? 32'(remw - {1'b0, len}) : remw[31:0];
      quo  <= {quo[QW-2:0], ge};
      dvd  <= dvd << 1;
    end
  end

endmodule

### sim/frustum_sphere_culler_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frustum_sphere_culler_chk
// Watches the command and result channels of the frustum sphere culler. It
// keeps its own copy of the matrices and planes, predicts every sphere
// verdict and compares it with the block's output.
// ----------------------------------------------------------------------------
module frustum_sphere_culler_chk #(
  parameter int FRAC = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         action,
  input  logic [1:0]         matrix_row,
  input  logic [1:0]         matrix_col,
  input  logic signed [31:0] element_value,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic [30:0]        sphere_radius,
  input  logic               inside_valid,
  input  logic               inside_res,
  output int                 fail_count,
  output int                 verdicts_pending
);
  import fsc_pkg::*;

  logic signed [31:0] view_m [16];
  logic signed [31:0] proj_m [16];
  logic signed [31:0] plane_m [24];
  logic               verdict_q [$];

  function automatic logic signed [31:0] clamp_word(input logic signed [65:0] v);
    if (v > 66'sh7fffffff) return 32'sh7fffffff;
    if (v < -66'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'h1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] scale_by_len(input logic signed [31:0] c,
                                                     input logic [63:0] len);
    logic [63:0]        mag, q;
    logic signed [65:0] s;
    mag = (c < 0) ? 64'(-longint'(c)) : 64'(longint'(c));
    q = (mag << FRAC) / len;
    s = (c < 0) ? -$signed({2'b00, q}) : $signed({2'b00, q});
    return clamp_word(s);
  endfunction

  task automatic rebuild_planes();
    logic signed [31:0] pm [4][4];
    logic signed [31:0] raw [6][4];
    logic signed [65:0] acc, c3;
    longint             prod;
    logic [63:0]        sq, len, csq;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) begin
          prod = longint'(view_m[i*4+k]) * longint'(proj_m[k*4+j]);
          acc = acc + 66'(prod >>> FRAC);
        end
        pm[i][j] = clamp_word(acc);
      end
    end
    for (int i = 0; i < 4; i++) begin
      c3 = 66'(pm[i][3]);
      raw[0][i] = clamp_word(c3 + 66'(pm[i][0]));
      raw[1][i] = clamp_word(c3 - 66'(pm[i][0]));
      raw[2][i] = clamp_word(c3 + 66'(pm[i][1]));
      raw[3][i] = clamp_word(c3 - 66'(pm[i][1]));
      raw[4][i] = pm[i][2];
      raw[5][i] = clamp_word(c3 - 66'(pm[i][2]));
    end
    for (int p = 0; p < 6; p++) begin
      sq = 0;
      for (int k = 0; k < 3; k++) begin
        csq = 64'(longint'(raw[p][k]) * longint'(raw[p][k]));
        sq = sq + csq;
      end
      len = floor_root(sq);
      for (int k = 0; k < 4; k++)
        plane_m[p*4+k] = (len == 0) ? 32'sd0 : scale_by_len(raw[p][k], len);
    end
  endtask

  function automatic logic sphere_verdict(input logic signed [31:0] cx,
                                          input logic signed [31:0] cy,
                                          input logic signed [31:0] cz,
                                          input logic [30:0] r);
    logic signed [95:0] d, lim;
    lim = -($signed({65'd0, r}) <<< FRAC);
    for (int p = 0; p < 6; p++) begin
      d = 96'(plane_m[p*4]) * 96'(cx) + 96'(plane_m[p*4+1]) * 96'(cy)
        + 96'(plane_m[p*4+2]) * 96'(cz) + (96'(plane_m[p*4+3]) <<< FRAC);
      if (d < lim) return 1'b0;
    end
    return 1'b1;
  endfunction

  assign verdicts_pending = verdict_q.size();

  always @(posedge clk) begin
    logic want;
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        view_m[i] = 0;
        proj_m[i] = 0;
      end
      for (int i = 0; i < 24; i++) plane_m[i] = 0;
      verdict_q.delete();
      fail_count = 0;
    end else begin
      // The result of a test and the transfer of the next command may meet.
      if (inside_valid) begin
        if (verdict_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected verdict inside_res=%0b", $realtime, inside_res);
        end else begin
          want = verdict_q.pop_front();
          if (inside_res !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: inside_res mismatch, expected %0b actual %0b",
                       $realtime, want, inside_res);
          end
        end
      end
      if (start && !busy) begin
        case (action)
          ACT_VIEW:   view_m[{matrix_row, matrix_col}] = element_value;
          ACT_PROJ:   proj_m[{matrix_row, matrix_col}] = element_value;
          ACT_UPDATE: rebuild_planes();
          default:    verdict_q.push_back(sphere_verdict(center_x, center_y, center_z,
                                                         sphere_radius));
        endcase
      end
    end
  end

  final begin
  end
endmodule

### sim/frustum_sphere_culler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frustum_sphere_culler_tb
// Drives matrix loads, plane updates and sphere tests into the culler under
// several idling patterns; a separate checker predicts and compares verdicts.
// ----------------------------------------------------------------------------
module frustum_sphere_culler_tb;
  import fsc_pkg::*;

  localparam int ONE         = 32'h0001_0000;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_ITEMS = 1400;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         action;
  logic [1:0]         matrix_row;
  logic [1:0]         matrix_col;
  logic signed [31:0] element_value;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic [30:0]        sphere_radius;
  logic               inside_valid;
  logic               inside_res;
  int                 fail_count;
  int                 verdicts_pending;
  int                 cycle_count;
  int                 idle_pct;
  int                 sent;

  frustum_sphere_culler uut (.*);
  frustum_sphere_culler_chk chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Presents one command and returns at the edge where it is transferred.
  task automatic issue(input logic [1:0] act, input logic [1:0] r, input logic [1:0] c,
                       input logic signed [31:0] ev, input logic signed [31:0] x,
                       input logic signed [31:0] y, input logic signed [31:0] z,
                       input logic [30:0] rad);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start         <= 1'b1;
    action        <= act;
    matrix_row    <= r;
    matrix_col    <= c;
    element_value <= ev;
    center_x      <= x;
    center_y      <= y;
    center_z      <= z;
    sphere_radius <= rad;
    // busy only changes at rising edges, so its value at the falling edge holds
    // at the next rising edge.
    do @(negedge clk); while (busy);
    @(posedge clk);
    sent++;
  endtask

  task automatic put_elem(input logic [1:0] act, input int idx, input logic signed [31:0] v);
    issue(act, idx[3:2], idx[1:0], v, $urandom, $urandom, $urandom, 31'($urandom));
  endtask

  task automatic run_update();
    issue(ACT_UPDATE, 2'($urandom), 2'($urandom), $urandom, $urandom, $urandom, $urandom,
          31'($urandom));
  endtask

  task automatic run_test(input logic signed [31:0] x, input logic signed [31:0] y,
                          input logic signed [31:0] z, input logic [30:0] rad);
    issue(ACT_TEST, 2'($urandom), 2'($urandom), $urandom, x, y, z, rad);
  endtask

  function automatic logic signed [31:0] small_fix();
    return $signed($urandom_range(8 * ONE)) - 4 * ONE;
  endfunction

  // Roughly a perspective projection and an identity view, with optional random noise.
  task automatic load_camera(input bit noisy);
    logic signed [31:0] v;
    for (int i = 0; i < 16; i++) begin
      v = (i % 5 == 0) ? ONE : 0;
      if (noisy) v = v + $signed($urandom_range(ONE / 2)) - ONE / 4;
      put_elem(ACT_VIEW, i, v);
    end
    for (int i = 0; i < 16; i++) begin
      case (i)
        0, 5:    v = ONE;
        10:      v = -ONE - ONE / 8;
        11:      v = -ONE;
        14:      v = -ONE / 4;
        default: v = 0;
      endcase
      if (noisy) v = v + $signed($urandom_range(ONE / 4)) - ONE / 8;
      put_elem(ACT_PROJ, i, v);
    end
    run_update();
  endtask

  function automatic logic signed [31:0] coord(input bit wide);
    return wide ? $signed($urandom) : $signed($urandom_range(32 * ONE)) - 16 * ONE;
  endfunction

  function automatic logic [30:0] radius(input bit wide);
    return wide ? 31'($urandom) : 31'($urandom_range(4 * ONE));
  endfunction

  initial begin
    int n;
    rst           <= 1'b1;
    start         <= 1'b0;
    action        <= ACT_VIEW;
    matrix_row    <= '0;
    matrix_col    <= '0;
    element_value <= 0;
    center_x      <= 0;
    center_y      <= 0;
    center_z      <= 0;
    sphere_radius <= '0;
    idle_pct = 0;
    sent = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: tests before any update, extreme coordinates, a zero normal,
    // saturating matrices and a normal camera.
    run_test(32'sh80000000, 32'sh7fffffff, 0, 31'h7fffffff);
    load_camera(1'b0);
    run_test(0, 0, -2 * ONE, 31'd0);
    run_test(0, 0, 32'sh7fffffff, 31'd0);
    run_test(32'sh80000000, 32'sh80000000, 32'sh80000000, 31'd0);
    run_test(32'sh7fffffff, 0, -2 * ONE, 31'h7fffffff);
    run_test(0, -40 * ONE, -2 * ONE, 31'(ONE));
    put_elem(ACT_VIEW, 0, 32'sh7fffffff);
    put_elem(ACT_PROJ, 3, 32'sh80000000);
    put_elem(ACT_PROJ, 15, 32'sh7fffffff);
    run_update();
    run_test(ONE, 32'sh80000000, 32'sh7fffffff, 31'd0);
    run_test(-ONE, ONE, ONE, 31'h7fffffff);
    for (int i = 0; i < 16; i++) put_elem(ACT_PROJ, i, 0);
    run_update();
    run_test(32'sh80000000, 32'sh80000000, 32'sh80000000, 31'd0);

    // Random: mostly sensible cameras with random spheres, some raw noise.
    n = 0;
    while (n < RANDOM_ITEMS) begin
      case ((n * 4) / RANDOM_ITEMS)
        0: idle_pct = 0;
        1: idle_pct = 52;
        2: idle_pct = 35;
        default: idle_pct = 52;
      endcase
      case ($urandom_range(9))
        0: begin
          load_camera(1'b1);
          n += 33;
        end
        1: begin
          repeat ($urandom_range(1, 6)) begin
            put_elem($urandom_range(1) ? ACT_VIEW : ACT_PROJ, $urandom_range(15),
                     $urandom_range(3) == 0 ? $signed($urandom) : small_fix());
            n++;
          end
          if ($urandom_range(2) == 0) begin
            run_update();
            n++;
          end
        end
        default: begin
          repeat ($urandom_range(1, 12)) begin
            run_test(coord($urandom_range(7) == 0), coord($urandom_range(7) == 0),
                     coord($urandom_range(7) == 0), radius($urandom_range(5) == 0));
            n++;
          end
        end
      endcase
    end
    start <= 1'b0;

    while (verdicts_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
